[hdl/avcwe_pkg.sv]
`timescale 1ns / 1ps

package avcwe_pkg;

  // drive power sequence
  typedef enum logic [2:0] {
    PH_INIT      = 3'd0,
    PH_RUN       = 3'd1,
    PH_WAIT_ON   = 3'd2,
    PH_WAIT_OPER = 3'd3,
    PH_WAIT_OFF  = 3'd4
  } phase_t;

  // status word matches and switch, decoded at the input register
  typedef struct packed {
    logic sw;
    logic st_ready;
    logic st_on;
    logic st_oper;
  } tick_t;

  // sequencer decision for the tick being finished
  typedef struct packed {
    logic       run_velocity;
    logic       waiting;
    logic [3:0] control_word;
  } seq_out_t;

  localparam logic [7:0] ST_MASK  = 8'hEF;
  localparam logic [7:0] ST_READY = 8'h21;
  localparam logic [7:0] ST_ON    = 8'h23;
  localparam logic [7:0] ST_OPER  = 8'h27;

  localparam logic [3:0] CW_SHUTDOWN  = 4'h6;
  localparam logic [3:0] CW_SWITCH_ON = 4'h7;
  localparam logic [3:0] CW_ENABLE    = 4'hF;

  localparam int VEL_W = 15;
  localparam logic signed [15:0] VEL_MAX = 16'sd16383;
  localparam logic signed [15:0] VEL_MIN = -16'sd16384;

  // products beyond these saturate anyway after the divide by 950
  localparam int CLAMP_W = 26;
  localparam logic signed [CLAMP_W-1:0] PROD_HI = 26'sd15564800;
  localparam logic signed [CLAMP_W-1:0] PROD_LO = -26'sd15565750;
  localparam int MAG_W = 24;

  // floor(m / 950) == (m * RECIP_K) >> RECIP_SHIFT for m < 2**24
  localparam int RECIP_W = 25;
  localparam logic [RECIP_W-1:0] RECIP_K = 25'd18084073;
  localparam int RECIP_SHIFT = 34;

  localparam logic [1:0] CFG_MAX_SPEED      = 2'd0;
  localparam logic [1:0] CFG_STEP_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_CREEP_LIMIT    = 2'd2;
  localparam logic [1:0] CFG_DEAD_OFFSET    = 2'd3;

  localparam int OUT_W = 24;

endpackage

[hdl/avcwe_scale.sv]
`timescale 1ns / 1ps

module avcwe_scale import avcwe_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  tick_t                          in_tick,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [7:0]                     max_speed,
  output logic                           out_valid,
  output tick_t                          out_tick,
  output logic signed [VEL_W-1:0]        out_velocity
);

  localparam int PW = SAMPLE_WIDTH + 9;
  localparam int EW = (PW > CLAMP_W) ? PW : CLAMP_W;

  logic                 s2_valid_r;
  tick_t                s2_tick_r;
  logic signed [PW-1:0] s2_prod_r;
  logic signed [PW-1:0] prod_nxt;

  logic                 s3_valid_r;
  tick_t                s3_tick_r;
  logic                 s3_neg_r;
  logic [VEL_W-1:0]     s3_quot_r;

  logic signed [EW-1:0] prod_ext;
  logic signed [EW-1:0] clamped;
  logic signed [EW-1:0] mag_full;
  logic [MAG_W-1:0]     mag;
  logic [MAG_W+RECIP_W-1:0] recip_prod;
  logic signed [15:0]   quot_s;
  logic signed [15:0]   signed_q;

  assign prod_nxt = in_sample * $signed({1'b0, max_speed});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= in_valid;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_tick_r <= in_tick;
      s2_prod_r <= prod_nxt;
      s3_tick_r <= s2_tick_r;
      s3_neg_r  <= clamped[EW-1];
      s3_quot_r <= recip_prod[RECIP_SHIFT +: VEL_W];
    end
  end

  // clamp first so the magnitude fits the reciprocal multiply
  always_comb begin
    prod_ext = EW'(s2_prod_r);
    if (prod_ext > EW'(PROD_HI)) begin
      clamped = EW'(PROD_HI);
    end else if (prod_ext < EW'(PROD_LO)) begin
      clamped = EW'(PROD_LO);
    end else begin
      clamped = prod_ext;
    end
    mag_full   = clamped[EW-1] ? -clamped : clamped;
    mag        = mag_full[MAG_W-1:0];
    recip_prod = {{RECIP_W{1'b0}}, mag} * {{MAG_W{1'b0}}, RECIP_K};
  end

  always_comb begin
    quot_s   = $signed({1'b0, s3_quot_r});
    signed_q = s3_neg_r ? -quot_s : quot_s;
    if (signed_q > VEL_MAX) begin
      out_velocity = VEL_MAX[VEL_W-1:0];
    end else if (signed_q < VEL_MIN) begin
      out_velocity = VEL_MIN[VEL_W-1:0];
    end else begin
      out_velocity = signed_q[VEL_W-1:0];
    end
  end

  assign out_valid = s3_valid_r;
  assign out_tick  = s3_tick_r;

endmodule

[hdl/avcwe_seq.sv]
`timescale 1ns / 1ps

module avcwe_seq import avcwe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  tick_t    tick,
  output seq_out_t seq
);

  phase_t     phase_r, phase_nxt;
  logic       enabled_r, enabled_nxt;
  logic [3:0] control_r, control_nxt;
  logic       run_body;
  logic       run_velocity;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_INIT;
      enabled_r <= 1'b0;
      control_r <= CW_SHUTDOWN;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      enabled_r <= enabled_nxt;
      control_r <= control_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    enabled_nxt  = enabled_r;
    control_nxt  = control_r;
    run_body     = 1'b0;
    run_velocity = 1'b0;

    unique case (phase_r)
      PH_INIT: begin
        if (tick.st_ready) run_body = 1'b1;
      end
      PH_WAIT_ON: begin
        if (tick.st_on) begin
          control_nxt = CW_ENABLE;
          phase_nxt   = PH_WAIT_OPER;
        end
      end
      PH_WAIT_OPER: begin
        if (tick.st_oper) begin
          phase_nxt    = PH_RUN;
          run_velocity = 1'b1;
        end
      end
      PH_WAIT_OFF: begin
        if (tick.st_ready) begin
          phase_nxt    = PH_RUN;
          run_velocity = 1'b1;
        end
      end
      PH_RUN: run_body = 1'b1;
      default: run_body = 1'b1;
    endcase

    // switch edge starts a wait, otherwise the tick produces a velocity
    if (run_body) begin
      phase_nxt = PH_RUN;
      if (tick.sw && !enabled_r) begin
        enabled_nxt = 1'b1;
        control_nxt = CW_SWITCH_ON;
        phase_nxt   = PH_WAIT_ON;
      end else if (!tick.sw && enabled_r) begin
        enabled_nxt = 1'b0;
        control_nxt = CW_SHUTDOWN;
        phase_nxt   = PH_WAIT_OFF;
      end else begin
        run_velocity = 1'b1;
      end
    end

    seq.run_velocity = run_velocity;
    seq.waiting      = (phase_nxt != PH_RUN);
    seq.control_word = control_nxt;
  end

endmodule

[hdl/avcwe_filter.sv]
`timescale 1ns / 1ps

module avcwe_filter import avcwe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    update,
  input  logic signed [VEL_W-1:0] vel_in,
  input  logic [5:0]              step_threshold,
  input  logic [5:0]              creep_limit,
  input  logic [7:0]              dead_offset,
  output logic signed [VEL_W-1:0] vel_out,
  output logic signed [VEL_W-1:0] last_vel
);

  logic signed [VEL_W-1:0] last_r;
  logic signed [6:0]       creep_r;
  logic signed [6:0]       creep_nxt;

  logic signed [16:0] v;
  logic signed [16:0] last;
  logic signed [16:0] thr;
  logic signed [16:0] dead;
  logic signed [16:0] vf;
  logic signed [16:0] tmp;
  logic signed [7:0]  cc;
  logic signed [7:0]  lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      creep_r <= '0;
    end else if (update) begin
      last_r  <= vel_out;
      creep_r <= creep_nxt;
    end
  end

  always_comb begin
    v    = 17'(vel_in);
    last = 17'(last_r);
    thr  = $signed({11'b0, step_threshold});
    dead = $signed({9'b0, dead_offset});
    lim  = $signed({2'b0, creep_limit});
    cc   = 8'(creep_r);
    vf   = v;
    tmp  = '0;

    if (v < last) begin
      if (last - v < thr) begin
        vf = last;
        cc = cc - 8'sd1;
        if (cc < -lim) begin
          // creep one step down, held at the range floor
          vf = (last == 17'(VEL_MIN)) ? last : last - 17'sd1;
          cc = '0;
        end
      end else begin
        cc = '0;
      end
    end else if (v > last) begin
      if (v - last < thr) begin
        vf = last;
        cc = cc + 8'sd1;
        if (cc > lim) begin
          vf = (last == 17'(VEL_MAX)) ? last : last + 17'sd1;
          cc = '0;
        end
      end else begin
        cc = '0;
      end
    end

    // dead offset pulls toward zero without crossing it
    if (vf > 17'sd0) begin
      tmp = vf - dead;
      vf  = (tmp < 17'sd0) ? 17'sd0 : tmp;
    end else if (vf < 17'sd0) begin
      tmp = vf + dead;
      vf  = (tmp > 17'sd0) ? 17'sd0 : tmp;
    end

    vel_out   = vf[VEL_W-1:0];
    creep_nxt = cc[6:0];
  end

  assign last_vel = last_r;

endmodule

[hdl/analog_velocity_command_with_enable.sv]
`timescale 1ns / 1ps

// Drive enable sequencer with a scaled, deadband-filtered velocity command.
// Input channel in_*: one control tick per transfer carrying the enable
// switch, the drive status word and an analog sample. Output channel out_*:
// exactly one result per tick with the control word, the target velocity and
// a waiting flag that is high while a status word match is still expected.
// The result passes through four registers: input register, sample times
// max_speed product register, reciprocal divide-by-950 register, then the
// sequencer and filter feeding the result register. Throughput is one tick
// per cycle; the whole pipeline moves together whenever the result register
// is empty or is being taken. When the receiver stalls, in_tready drops in
// the same cycle and every stage holds its item; nothing is dropped or
// repeated.
// Reset (rst_n low, synchronous) empties the pipeline, puts the sequencer in
// the initial wait for a ready status with control word 6, clears the filter
// state and loads the default register values.
// The user must write registers through cfg_we/cfg_addr/cfg_wdata only while
// no tick is in flight; the block itself does not enforce this.
module analog_velocity_command_with_enable import avcwe_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // enable_switch, status_word[15:0], analog_sample, zero fill
  input  logic [((17 + SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                out_tvalid,
  input  logic                out_tready,
  // control_word[3:0], target_velocity[14:0], waiting, zero fill
  output logic [OUT_W-1:0]    out_tdata,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [7:0]          cfg_wdata
);

  logic [7:0] max_speed_r;
  logic [5:0] step_threshold_r;
  logic [5:0] creep_limit_r;
  logic [7:0] dead_offset_r;

  logic                           adv;
  logic                           s1_valid_r;
  tick_t                          s1_tick_r;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_r;
  tick_t                          in_tick;
  logic [7:0]                     st_masked;

  logic                    sc_valid;
  tick_t                   sc_tick;
  logic signed [VEL_W-1:0] sc_velocity;

  seq_out_t                seq;
  logic                    fire;
  logic signed [VEL_W-1:0] filt_vel;
  logic signed [VEL_W-1:0] last_vel;

  logic                    out_valid_r;
  logic [3:0]              out_cw_r;
  logic [VEL_W-1:0]        out_vel_r;
  logic                    out_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_speed_r      <= 8'd200;
      step_threshold_r <= 6'd5;
      creep_limit_r    <= 6'd20;
      dead_offset_r    <= 8'd10;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_SPEED:      max_speed_r      <= cfg_wdata;
        CFG_STEP_THRESHOLD: step_threshold_r <= cfg_wdata[5:0];
        CFG_CREEP_LIMIT:    creep_limit_r    <= cfg_wdata[5:0];
        CFG_DEAD_OFFSET:    dead_offset_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  assign st_masked = in_tdata[8:1] & ST_MASK;

  always_comb begin
    in_tick.sw       = in_tdata[0];
    in_tick.st_ready = (st_masked == ST_READY);
    in_tick.st_on    = (st_masked == ST_ON);
    in_tick.st_oper  = (st_masked == ST_OPER);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tick_r   <= in_tick;
      s1_sample_r <= in_tdata[17 +: SAMPLE_WIDTH];
    end
  end

  avcwe_scale #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_scale (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .in_valid     (s1_valid_r),
    .in_tick      (s1_tick_r),
    .in_sample    (s1_sample_r),
    .max_speed    (max_speed_r),
    .out_valid    (sc_valid),
    .out_tick     (sc_tick),
    .out_velocity (sc_velocity)
  );

  assign fire = adv && sc_valid;

  avcwe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .tick  (sc_tick),
    .seq   (seq)
  );

  avcwe_filter u_filter (
    .clk            (clk),
    .rst_n          (rst_n),
    .update         (fire && seq.run_velocity),
    .vel_in         (sc_velocity),
    .step_threshold (step_threshold_r),
    .creep_limit    (creep_limit_r),
    .dead_offset    (dead_offset_r),
    .vel_out        (filt_vel),
    .last_vel       (last_vel)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sc_valid;
    end
  end

  // waiting ticks repeat the last filtered velocity
  always_ff @(posedge clk) begin
    if (fire) begin
      out_cw_r   <= seq.control_word;
      out_vel_r  <= seq.run_velocity ? filt_vel : last_vel;
      out_wait_r <= seq.waiting;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - 20){1'b0}}, out_wait_r, out_vel_r, out_cw_r};

`ifndef NO_ASSERTIONS
  // outside a wait the drive is either shut down or fully enabled
  a_settled_cw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[19] |-> out_tdata[3:0] == CW_SHUTDOWN ||
                                     out_tdata[3:0] == CW_ENABLE)
    else $error("settled result with switch-on control word");

  // an accepted tick is held in the input register on the next edge
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid_r)
    else $error("accepted tick lost at input register");

  // an empty result register never stalls the input side
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while result register empty");
`endif

endmodule

[dv/tb_analog_velocity_command_with_enable.sv]
`timescale 1ns / 1ps

module tb_analog_velocity_command_with_enable;
  import avcwe_pkg::*;

  localparam int TICK_W         = 40;
  localparam int SCALE_DIV      = 950;
  localparam int PIPE_CYCLES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic               en;
    logic [15:0]        status;
    logic signed [15:0] sample;
  } drive_tick_t;

  typedef struct {
    logic [3:0]  control;
    logic [14:0] velocity;
    logic        waiting;
  } drive_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [TICK_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_addr = '0;
  logic [7:0]        cfg_wdata = '0;

  analog_velocity_command_with_enable u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  drive_tick_t   tick_queue[$];
  drive_result_t expected_commands[$];
  int            mismatch_count = 0;

  // register mirror
  int max_speed = 200;
  int step_thr  = 5;
  int creep_lim = 20;
  int dead_off  = 10;

  // sequencer and filter state
  phase_t     drv_phase    = PH_INIT;
  logic       drv_enabled  = 1'b0;
  logic [3:0] drv_control  = CW_SHUTDOWN;
  int         drv_velocity = 0;
  int         drv_last_vel = 0;
  int         drv_creep    = 0;

  function automatic int clamp_velocity(int v);
    if (v < -16384) return -16384;
    if (v > 16383) return 16383;
    return v;
  endfunction

  function automatic int deadband_filter(int v);
    if (v < drv_last_vel) begin
      if (drv_last_vel - v < step_thr) begin
        v = drv_last_vel;
        drv_creep--;
        if (drv_creep < -creep_lim) begin
          v = clamp_velocity(v - 1);
          drv_creep = 0;
        end
      end else begin
        drv_creep = 0;
      end
    end else if (v > drv_last_vel) begin
      if (v - drv_last_vel < step_thr) begin
        v = drv_last_vel;
        drv_creep++;
        if (drv_creep > creep_lim) begin
          v = clamp_velocity(v + 1);
          drv_creep = 0;
        end
      end else begin
        drv_creep = 0;
      end
    end
    if (v > 0) begin
      v -= dead_off;
      if (v < 0) v = 0;
    end else if (v < 0) begin
      v += dead_off;
      if (v > 0) v = 0;
    end
    drv_last_vel = v;
    return v;
  endfunction

  function automatic drive_result_t advance_drive(drive_tick_t t);
    logic [7:0]    st;
    logic          body;
    logic          run_vel;
    drive_result_t r;
    st = t.status[7:0] & ST_MASK;
    body = 1'b0;
    run_vel = 1'b0;
    case (drv_phase)
      PH_INIT: begin
        if (st == ST_READY) body = 1'b1;
      end
      PH_WAIT_ON: begin
        if (st == ST_ON) begin
          drv_control = CW_ENABLE;
          drv_phase = PH_WAIT_OPER;
        end
      end
      PH_WAIT_OPER: begin
        if (st == ST_OPER) begin
          drv_phase = PH_RUN;
          run_vel = 1'b1;
        end
      end
      PH_WAIT_OFF: begin
        if (st == ST_READY) begin
          drv_phase = PH_RUN;
          run_vel = 1'b1;
        end
      end
      default: body = 1'b1;
    endcase
    if (body) begin
      drv_phase = PH_RUN;
      if (t.en && !drv_enabled) begin
        drv_enabled = 1'b1;
        drv_control = CW_SWITCH_ON;
        drv_phase = PH_WAIT_ON;
      end else if (!t.en && drv_enabled) begin
        drv_enabled = 1'b0;
        drv_control = CW_SHUTDOWN;
        drv_phase = PH_WAIT_OFF;
      end else begin
        run_vel = 1'b1;
      end
    end
    // division truncates toward zero
    if (run_vel)
      drv_velocity = deadband_filter(clamp_velocity((int'(t.sample) * max_speed) / SCALE_DIV));
    r.control = drv_control;
    r.velocity = drv_velocity[14:0];
    r.waiting = (drv_phase != PH_RUN);
    return r;
  endfunction

  // sender: bursts with gaps, sometimes holds off until all results are back
  drive_tick_t cur_tick;
  int          burst_left = 1;
  int          gap_left = 0;
  logic        draining = 1'b0;
  logic        next_valid;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_commands.push_back(advance_drive(cur_tick));
      next_valid = 1'b0;
      if (in_tvalid && !in_tready) begin
        next_valid = 1'b1;
      end else if (draining) begin
        if (expected_commands.size() == 0) draining = 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (tick_queue.size() > 0) begin
        cur_tick = tick_queue.pop_front();
        in_tdata <= {7'b0, cur_tick.sample, cur_tick.status, cur_tick.en};
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          draining = ($urandom_range(0, 24) == 0);
        end
      end
      in_tvalid <= next_valid;
    end
  end

  // receiver: switches at random between four stall modes, paced by stall_cnt
  int            stall_cnt = 0;
  int            stall_mode = 0;
  logic          next_ready;
  drive_result_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_commands.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          mismatch_count++;
        end else begin
          exp_r = expected_commands.pop_front();
          if (out_tdata[3:0] !== exp_r.control) begin
            $error("control_word expected %0d got %0d", exp_r.control, out_tdata[3:0]);
            mismatch_count++;
          end
          if (out_tdata[18:4] !== exp_r.velocity) begin
            $error("target_velocity expected %0d got %0d",
                   $signed(exp_r.velocity), $signed(out_tdata[18:4]));
            mismatch_count++;
          end
          if (out_tdata[19] !== exp_r.waiting) begin
            $error("waiting expected %0d got %0d", exp_r.waiting, out_tdata[19]);
            mismatch_count++;
          end
        end
      end
      stall_cnt++;
      if (stall_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: next_ready = 1'b1;
        1: next_ready = 1'($urandom_range(0, 1));
        2: next_ready = (stall_cnt % 4 == 0);
        default: next_ready = ($urandom_range(0, 7) != 0);
      endcase
      out_tready <= next_ready;
    end
  end

  // watchdog on cycles without any transfer
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // stimulus generation
  int   gen_sample = 0;
  int   seg_left = 0;
  int   seg_mode = 0;
  int   seg_dir = 1;
  logic gen_en = 1'b0;

  task automatic push_tick(input logic en, input logic [15:0] status, input int sample);
    drive_tick_t t;
    t.en = en;
    t.status = status;
    t.sample = sample[15:0];
    tick_queue.push_back(t);
  endtask

  function automatic int next_sample();
    int v;
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 4);
      seg_left = $urandom_range(8, 60);
      seg_dir = $urandom_range(0, 1) ? 1 : -1;
      if (seg_mode == 0 && $urandom_range(0, 1)) gen_sample = int'($urandom_range(0, 40)) - 20;
    end
    seg_left--;
    case (seg_mode)
      // slow ramps let held changes pile up into creep steps
      0: v = gen_sample + seg_dir * int'($urandom_range(0, 6));
      1: v = gen_sample + int'($urandom_range(0, 40)) - 20;
      2: v = int'($urandom_range(0, 65535)) - 32768;
      3: v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = gen_sample + int'($urandom_range(0, 600)) - 300;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    gen_sample = v;
    return v;
  endfunction

  task automatic fill_random(input int n);
    logic [7:0] hi;
    logic [7:0] lo;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 11) == 0) gen_en = ~gen_en;
      hi = 8'($urandom_range(0, 255));
      // bit 4 is masked off by the block
      case ($urandom_range(0, 9))
        0, 1: lo = ST_READY | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
        2, 3: lo = ST_ON | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
        4, 5: lo = ST_OPER | ($urandom_range(0, 1) ? 8'h10 : 8'h00);
        default: lo = 8'($urandom_range(0, 255));
      endcase
      push_tick(gen_en, {hi, lo}, next_sample());
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_SPEED:      max_speed = int'(val);
      CFG_STEP_THRESHOLD: step_thr = int'(val[5:0]);
      CFG_CREEP_LIMIT:    creep_lim = int'(val[5:0]);
      default:            dead_off = int'(val);
    endcase
  endtask

  task automatic apply_settings(input int ms, input int thr, input int lim, input int dead);
    write_reg(CFG_MAX_SPEED, ms[7:0]);
    write_reg(CFG_STEP_THRESHOLD, thr[7:0]);
    write_reg(CFG_CREEP_LIMIT, lim[7:0]);
    write_reg(CFG_DEAD_OFFSET, dead[7:0]);
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_tvalid || expected_commands.size() != 0)
      @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the power sequence with the reset settings
    push_tick(1'b0, 16'h0000, 0);          // initial wait, no match
    push_tick(1'b0, 16'h0020, 1000);
    push_tick(1'b0, 16'hFF21, 32767);      // ready with upper byte set
    push_tick(1'b0, 16'h0031, -32768);     // masked bit set
    push_tick(1'b0, 16'h0000, 0);
    push_tick(1'b0, 16'h0000, 5);          // small change held
    push_tick(1'b0, 16'h0000, 15);
    push_tick(1'b1, 16'h0000, 100);        // rising switch
    push_tick(1'b1, 16'h0000, 200);
    push_tick(1'b1, 16'h0033, 300);        // switch-on match, enable written
    push_tick(1'b1, 16'h0021, 400);
    push_tick(1'b1, 16'hA537, 32767);      // operation enabled match
    push_tick(1'b1, 16'hFFFF, -1);
    push_tick(1'b0, 16'h0000, 0);          // falling switch
    push_tick(1'b0, 16'h0023, 0);
    push_tick(1'b0, 16'h1021, -32768);     // disable match
    push_tick(1'b1, 16'hFFFF, 32767);
    push_tick(1'b0, 16'h0023, 0);
    push_tick(1'b0, 16'h0027, 0);          // enabled flag still set
    push_tick(1'b0, 16'h0000, 0);          // switch low now seen as falling
    push_tick(1'b0, 16'h0021, 16384);
    gen_en = 1'b0;
    fill_random(80);
    wait_drained();

    apply_settings(255, 63, 63, 255);
    fill_random(85);
    wait_drained();

    apply_settings(0, 1, 1, 0);
    fill_random(85);
    wait_drained();

    // threshold 0 holds no change; creep limit 0 would creep any held change at once
    apply_settings(200, 0, 0, 0);
    fill_random(85);
    wait_drained();

    apply_settings(255, 8, 3, 0);
    fill_random(90);
    wait_drained();

    apply_settings(128, 63, 1, 0);
    fill_random(80);
    wait_drained();

    apply_settings($urandom_range(0, 255), $urandom_range(1, 63), $urandom_range(1, 63),
                   $urandom_range(0, 255));
    fill_random(80);
    wait_drained();

    apply_settings($urandom_range(0, 255), $urandom_range(1, 63), $urandom_range(1, 63),
                   $urandom_range(0, 20));
    fill_random(80);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
